### src/push_only_script_checker_core_defines.svh
// Assertion helpers shared by the checker RTL.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef PUSH_ONLY_SCRIPT_CHECKER_CORE_DEFINES_SVH
`define PUSH_ONLY_SCRIPT_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is asserted (active low reset).
`define POCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("push_only_script_checker: assertion failed");

// Check that must hold at every edge, reset included.
`define POCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("push_only_script_checker: invariant failed");

`else

`define POCS_ASSERT(lbl, clk, rst_n, prop)

`define POCS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### src/pocs_pkg.sv
package pocs_pkg;

    // Parser phase; codes 6 and 7 never arise and are treated as failed.
    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LEN2_LO = 3'd3,
        PH_LEN2_HI = 3'd4,
        PH_FAILED  = 3'd5
    } t_phase;

    localparam logic [7:0] MAX_DIRECT_PUSH = 8'd75;
    localparam logic [7:0] OPC_0           = 8'h00;
    localparam logic [7:0] OPC_PUSHDATA1   = 8'h4C;
    localparam logic [7:0] OPC_PUSHDATA2   = 8'h4D;
    localparam logic [7:0] OPC_1NEGATE     = 8'h4F;
    localparam logic [7:0] OPC_1           = 8'h51;
    localparam logic [7:0] OPC_16          = 8'h60;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] skip_left;
        logic [7:0]  length_low;
    } t_parse_state;

    localparam t_parse_state PARSE_STATE_RESET = '{
        phase:      PH_OPCODE,
        skip_left:  16'd0,
        length_low: 8'd0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

endpackage

### src/pocs_if.sv
// Script byte channel.
interface pocs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

// Verdict channel.
interface pocs_out_if;
    logic valid;
    logic ready;
    logic push_only;

    modport source (output valid, output push_only, input ready);
    modport sink   (input valid, input push_only, output ready);
endinterface

### src/pocs_step.sv
module pocs_step (
    input  pocs_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_has_byte,
    output pocs_pkg::t_parse_state o_state,
    output logic                   o_push_ok
);
    import pocs_pkg::*;

    t_parse_state byte_state;
    logic [15:0]  skip_len;
    logic         load_skip;
    logic [15:0]  skip_dec;

    assign skip_dec = i_state.skip_left - 16'd1;

    always_comb begin
        byte_state = i_state;
        skip_len   = 16'd0;
        load_skip  = 1'b0;
        unique case (i_state.phase)
            PH_OPCODE: begin
                if (i_byte >= 8'd1 && i_byte <= MAX_DIRECT_PUSH) begin
                    skip_len  = {8'd0, i_byte};
                    load_skip = 1'b1;
                end else if (i_byte == OPC_PUSHDATA1) begin
                    byte_state.phase = PH_LEN1;
                end else if (i_byte == OPC_PUSHDATA2) begin
                    byte_state.phase = PH_LEN2_LO;
                end else if (i_byte == OPC_0 || i_byte == OPC_1NEGATE ||
                             (i_byte >= OPC_1 && i_byte <= OPC_16)) begin
                    byte_state.phase = PH_OPCODE;
                end else begin
                    byte_state.phase = PH_FAILED;
                end
            end
            PH_SKIP: begin
                byte_state.skip_left = skip_dec;
                if (skip_dec == 16'd0) begin
                    byte_state.phase = PH_OPCODE;
                end
            end
            PH_LEN1: begin
                skip_len  = {8'd0, i_byte};
                load_skip = 1'b1;
            end
            PH_LEN2_LO: begin
                byte_state.length_low = i_byte;
                byte_state.phase      = PH_LEN2_HI;
            end
            PH_LEN2_HI: begin
                skip_len  = {i_byte, i_state.length_low};
                load_skip = 1'b1;
            end
            default: begin
                byte_state.phase = PH_FAILED;
            end
        endcase

        // zero length drops straight back to opcode
        if (load_skip) begin
            byte_state.skip_left = skip_len;
            byte_state.phase     = (skip_len != 16'd0) ? PH_SKIP : PH_OPCODE;
        end
    end

    assign o_state   = i_has_byte ? byte_state : i_state;
    assign o_push_ok = (o_state.phase == PH_OPCODE) || (o_state.phase == PH_SKIP);

endmodule

### src/push_only_script_checker_core.sv
// Channel  | Dir | Payload                         | Transaction
// ---------+-----+---------------------------------+------------------------------
// i_in     | in  | data_byte[7:0] has_byte last    | one script byte or end marker
// o_out    | out | push_only                       | one verdict per script
//
// Each transaction enters a one-deep input register; the parser step runs on it
// there and, for a last item, the verdict then lands in the output register.
// Sustained rate is one transaction per cycle unless a last item waits on a stalled o_out.
// i_rst_n is synchronous and active low; it clears parser state and both valids.
// A stalled o_out holds the input stage only when it carries a last item;
// plain bytes keep moving, so i_in.ready drops only with both registers full.
`include "push_only_script_checker_core_defines.svh"

module push_only_script_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pocs_in_if.sink     i_in,
    pocs_out_if.source  o_out
);
    import pocs_pkg::*;

    // Input register stage
    logic         r_s1_valid;
    t_item        r_s1;

    // Parser state carried across bytes of one script
    t_parse_state r_state;
    t_parse_state n_state;
    logic         step_ok;

    // Output register
    logic         r_out_valid;
    logic         r_out_push_only;

    logic         s1_go;
    logic         in_fire;

    // A last item needs the output register free (or draining this cycle).
    assign s1_go   = r_s1_valid && (!r_s1.last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.data_byte <= i_in.data_byte;
            r_s1.has_byte  <= i_in.has_byte;
            r_s1.last      <= i_in.last;
        end
    end

    pocs_step u_step (
        .i_state    (r_state),
        .i_byte     (r_s1.data_byte),
        .i_has_byte (r_s1.has_byte),
        .o_state    (n_state),
        .o_push_ok  (step_ok)
    );

    // Script state returns to reset after its last item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_STATE_RESET;
        end else if (s1_go) begin
            r_state <= r_s1.last ? PARSE_STATE_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1.last) begin
            r_out_push_only <= step_ok;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.push_only = r_out_push_only;

    // A verdict appears only from a last item leaving the input stage.
    `POCS_ASSERT(a_verdict_from_last, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(s1_go && r_s1.last))
    // Parser is back at its reset state after a script ends.
    `POCS_ASSERT(a_state_cleared, i_clk, i_rst_n,
        $past(s1_go && r_s1.last) |-> (r_state == PARSE_STATE_RESET))
    // Input backpressure only when both registers are occupied.
    `POCS_ASSERT(a_ready_low_full, i_clk, i_rst_n,
        !i_in.ready |-> (r_s1_valid && r_s1.last && r_out_valid))
    // Skip phase always has bytes left to skip.
    `POCS_ASSERT_ALWAYS(a_skip_nonzero, i_clk,
        (r_state.phase == PH_SKIP) |-> (r_state.skip_left != 16'd0))

endmodule

### verif/push_only_verdict_monitor.sv
`timescale 1ns / 1ps

// Watches both channels, runs its own parser on every accepted script byte
// and checks each verdict against the oldest one still owed.
module push_only_verdict_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    pocs_in_if   i_in,
    pocs_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import pocs_pkg::*;

    t_parse_state parse_st = PARSE_STATE_RESET;
    logic         verdict_q[$];
    logic         want;
    int           err_total   = 0;
    int           verdict_idx = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] verdict #%0d: %s", $realtime, verdict_idx, msg);
        err_total++;
    endtask

    // Arm a data skip; a zero length goes straight back to opcode.
    function automatic t_parse_state arm_skip(input t_parse_state s, input logic [15:0] len);
        t_parse_state n;
        n           = s;
        n.skip_left = len;
        n.phase     = (len != 16'd0) ? PH_SKIP : PH_OPCODE;
        return n;
    endfunction

    function automatic t_parse_state take_script_byte(input t_parse_state s,
                                                      input logic [7:0] b);
        t_parse_state n;
        n = s;
        case (s.phase)
            PH_OPCODE: begin
                if (b >= 8'd1 && b <= MAX_DIRECT_PUSH) begin
                    n = arm_skip(s, {8'd0, b});
                end else if (b == OPC_PUSHDATA1) begin
                    n.phase = PH_LEN1;
                end else if (b == OPC_PUSHDATA2) begin
                    n.phase = PH_LEN2_LO;
                end else if (b == OPC_0 || b == OPC_1NEGATE || (b >= OPC_1 && b <= OPC_16)) begin
                    n.phase = PH_OPCODE;
                end else begin
                    n.phase = PH_FAILED;
                end
            end
            PH_SKIP: begin
                n.skip_left = s.skip_left - 16'd1;
                if (n.skip_left == 16'd0) n.phase = PH_OPCODE;
            end
            PH_LEN1:    n = arm_skip(s, {8'd0, b});
            PH_LEN2_LO: begin
                n.length_low = b;
                n.phase      = PH_LEN2_HI;
            end
            PH_LEN2_HI: n = arm_skip(s, {b, s.length_low});
            default:    n.phase = PH_FAILED;
        endcase
        return n;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.has_byte) parse_st = take_script_byte(parse_st, i_in.data_byte);
                if (i_in.last) begin
                    verdict_q.insert(verdict_q.size(), parse_st.phase == PH_OPCODE ||
                                                       parse_st.phase == PH_SKIP);
                    parse_st = PARSE_STATE_RESET;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("push_only=%b with no script pending",
                                              i_out.push_only));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out.push_only !== want)
                        report_mismatch($sformatf("push_only=%b, want %b",
                                                  i_out.push_only, want));
                end
                verdict_idx++;
            end
        end
        o_fail_count <= err_total;
        o_pending    <= verdict_q.size();
    end

endmodule

### verif/push_only_script_checker_core_tb.sv
`timescale 1ns / 1ps

module push_only_script_checker_core_tb;
    import pocs_pkg::*;

    // Opcodes that must fail the script.
    localparam logic [7:0] OPC_RESERVED  = 8'h50;
    localparam logic [7:0] OPC_PUSHDATA4 = 8'h4E;
    localparam logic [7:0] OPC_TOP_BYTE  = 8'hFF;

    localparam int NUM_ITEMS      = 1900;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pocs_in_if  in_ch();
    pocs_out_if out_ch();

    int fail_count;
    int pending;

    push_only_script_checker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    push_only_verdict_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Script under construction; one entry per script byte.
    logic [7:0] script_q[$];
    int         byte_items = 0;  // counted items (noise excluded)
    logic       no_gaps    = 1'b0;

    // Append one byte to the script under construction.
    function automatic void add_byte(input logic [7:0] b);
        script_q.insert(script_q.size(), b);
    endfunction

    // Drive one transaction. valid only drops when a gap is drawn, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic send_item(input t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= it.data_byte;
        in_ch.has_byte  <= it.has_byte;
        in_ch.last      <= it.last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stream script_q. Either the last byte carries last, or a bare end
    // marker follows (always so for an empty script). Stray bare non-last
    // items are sprinkled in; the block must ignore them.
    task automatic send_script(input bit bare_end);
        int n;
        n = script_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(t_item'{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b0});
            send_item(t_item'{data_byte: script_q[i], has_byte: 1'b1,
                              last: !bare_end && (i == n - 1)});
            byte_items++;
        end
        if (bare_end || n == 0) begin
            send_item(t_item'{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b1});
            byte_items++;
        end
    endtask

    // Verdict sink: random stall before each verdict, with bursts of none.
    initial begin
        int  stall;
        bit  burst;
        out_ch.ready <= 1'b0;
        burst = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 7) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("push_only_script_checker_core_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         n_ops;
        int         len;
        int         pos;
        bit         stop;
        logic [15:0] len16;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.has_byte  <= 1'b0;
        in_ch.last      <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed scripts ----
        // Empty script: lone end marker, push_only expected.
        script_q.delete();
        send_script(1'b1);
        // Bare non-last item between scripts changes nothing.
        send_item(t_item'{data_byte: OPC_TOP_BYTE, has_byte: 1'b0, last: 1'b0});
        // Every standalone push kind.
        script_q = '{OPC_0, OPC_1NEGATE, OPC_1, OPC_16};
        send_script(1'b0);
        // Non-push opcodes, one script each.
        script_q = '{OPC_RESERVED};
        send_script(1'b0);
        script_q = '{OPC_PUSHDATA4};
        send_script(1'b0);
        script_q = '{OPC_TOP_BYTE};
        send_script(1'b0);
        // Length prefix cut short: PUSHDATA1 without length, PUSHDATA2 without high byte.
        script_q = '{OPC_PUSHDATA1};
        send_script(1'b1);
        script_q = '{OPC_PUSHDATA2, OPC_TOP_BYTE};
        send_script(1'b1);
        // Zero-length pushes return to opcode at once.
        script_q = '{OPC_PUSHDATA2, OPC_0, OPC_0, OPC_16};
        send_script(1'b0);
        script_q = '{OPC_PUSHDATA1, OPC_0};
        send_script(1'b0);
        // Largest direct push with its data cut short still passes.
        script_q = '{MAX_DIRECT_PUSH, 8'hA5, 8'h5A};
        send_script(1'b0);

        // ---- random scripts ----
        // Mostly well-formed op sequences with random data; about one in five
        // gets broken (stray byte, dangling prefix, truncation, pure noise).
        while (byte_items < NUM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) no_gaps = !no_gaps;
            script_q.delete();
            n_ops = $urandom_range(0, 6);
            stop  = 1'b0;
            for (int k = 0; k < n_ops && !stop; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        case ($urandom_range(0, 2))
                            0:       add_byte(OPC_0);
                            1:       add_byte(OPC_1NEGATE);
                            default: add_byte(OPC_1 + 8'($urandom_range(0, 15)));
                        endcase
                    end
                    2, 3, 4: begin
                        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_DIRECT_PUSH)
                                                          : $urandom_range(1, 6);
                        add_byte(8'(len));
                        repeat (len) add_byte(8'($urandom));
                    end
                    5, 6: begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 6);
                        add_byte(OPC_PUSHDATA1);
                        add_byte(8'(len));
                        repeat (len) add_byte(8'($urandom));
                    end
                    7, 8: begin
                        len = $urandom_range(0, 6);
                        add_byte(OPC_PUSHDATA2);
                        add_byte(8'(len));
                        add_byte(OPC_0);
                        repeat (len) add_byte(8'($urandom));
                    end
                    default: begin
                        // Full 16-bit length, data cut short by the end of the script.
                        len16 = 16'($urandom);
                        add_byte(OPC_PUSHDATA2);
                        add_byte(len16[7:0]);
                        add_byte(len16[15:8]);
                        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                        stop = 1'b1;
                    end
                endcase
            end
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        pos = $urandom_range(0, script_q.size());
                        script_q.insert(pos, 8'($urandom));
                    end
                    1: begin
                        if ($urandom_range(0, 1) == 0) begin
                            add_byte(OPC_PUSHDATA1);
                        end else begin
                            add_byte(OPC_PUSHDATA2);
                            if ($urandom_range(0, 1) == 0) add_byte(8'($urandom));
                        end
                    end
                    2: begin
                        pos = $urandom_range(0, script_q.size());
                        while (script_q.size() > pos) void'(script_q.pop_back());
                    end
                    default: begin
                        script_q.delete();
                        repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
                    end
                endcase
            end
            send_script($urandom_range(0, 3) == 0);
        end

        in_ch.valid <= 1'b0;
        // Let the monitor register the final transaction before polling it.
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("push_only_script_checker_core_tb: clean");
        end else begin
            $display("push_only_script_checker_core_tb: errors");
        end
        $finish;
    end

endmodule
